@@ rtl/core/klc_pkg.sv @@
// ----------------------------------------------------------------------------
// klc_pkg
// Types, character codes and the keyword table for the lexeme classifier.
// ----------------------------------------------------------------------------
package klc_pkg;

    localparam int CHAR_W  = 8;
    localparam int CNT_W   = 4;
    localparam int TEXT_W  = 64;
    localparam int CLASS_W = 3;
    localparam int KW_NUM  = 6;

    typedef logic [CHAR_W-1:0]  char_t;
    typedef logic [CNT_W-1:0]   count_t;
    typedef logic [TEXT_W-1:0]  text_t;
    typedef logic [CLASS_W-1:0] class_t;

    localparam class_t CLS_KEYWORD   = 3'd0;
    localparam class_t CLS_INTEGER   = 3'd1;
    localparam class_t CLS_OPERATOR  = 3'd2;
    localparam class_t CLS_IDENT     = 3'd3;
    localparam class_t CLS_SEPARATOR = 3'd4;

    localparam char_t CH_NUL    = 8'h00;
    localparam char_t CH_LF     = 8'h0a;
    localparam char_t CH_SPACE  = 8'h20;
    localparam char_t CH_PERIOD = 8'h2e;
    localparam char_t CH_PLUS   = 8'h2b;
    localparam char_t CH_MINUS  = 8'h2d;
    localparam char_t CH_STAR   = 8'h2a;
    localparam char_t CH_SLASH  = 8'h2f;
    localparam char_t CH_ZERO   = 8'h30;
    localparam char_t CH_NINE   = 8'h39;

    // first character in the lowest byte, unused bytes zero
    localparam text_t KW_TEXT [KW_NUM] = '{
        64'h0000_0000_0000_6669,  // if
        64'h0000_0000_6573_6c65,  // else
        64'h0000_0074_6e69_7270,  // print
        64'h0000_6e67_6973_7361,  // assign
        64'h0000_0073_656d_6974,  // times
        64'h656c_6261_6972_6176   // variable
    };
    localparam count_t KW_LEN [KW_NUM] = '{4'd2, 4'd4, 4'd5, 4'd6, 4'd5, 4'd8};

endpackage

@@ rtl/core/keyword_lexeme_classifier.sv @@
// ----------------------------------------------------------------------------
// keyword_lexeme_classifier
// Gathers characters into lexemes and emits classified tokens.
// ----------------------------------------------------------------------------
// One char per beat, one per cycle with m_tready high and no separator queued.
// Non-delimiters are stored (up to MAX_LEXEME bytes, the rest dropped and
// flagged). Space, period, newline or NUL ends the lexeme: a non-empty lexeme
// gives one token beat, classed keyword, integer, operator or identifier; a
// period then gives a separator beat. Results leave through a one-beat output
// register, so a character is taken in the same cycle its predecessor's token
// is taken, and s_tready is low while a token waits with m_tready low. A
// period ending a non-empty lexeme makes two beats; s_tready is low while the
// queued separator waits behind the token, until m_tready is high.
// m_tlast marks the last beat caused by a character.
module keyword_lexeme_classifier #(
    parameter int MAX_LEXEME = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  klc_pkg::char_t       s_tdata,   // [7:0] char_code
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [71:0]          m_tdata,   // [3:0] lexeme_length, [67:4] lexeme_text,
                                            // [68] truncated, [71:69] zero
    output klc_pkg::class_t      m_tuser,   // [2:0] token_class
    output logic                 m_tlast    // last_of_run
);
    import klc_pkg::*;

    localparam int IDX_W = $clog2(MAX_LEXEME);

    char_t  buf_reg [MAX_LEXEME];
    count_t cnt_reg, cnt_next;
    logic   ovf_reg, ovf_next;
    logic   dig_reg, dig_next;

    logic   res_valid_reg, res_valid_next;
    logic   sep_pend_reg, sep_pend_next;
    class_t res_class_reg, res_class_next;
    count_t res_len_reg, res_len_next;
    text_t  res_text_reg, res_text_next;
    logic   res_trunc_reg, res_trunc_next;
    logic   res_last_reg, res_last_next;

    logic   take, is_delim, is_period, is_digit, room;
    text_t  lex_text;
    logic   kw_hit;
    class_t tok_class;

    assign s_tready  = !sep_pend_reg && (!res_valid_reg || m_tready);
    assign take      = s_tvalid && s_tready;
    assign is_period = (s_tdata == CH_PERIOD);
    assign is_delim  = (s_tdata == CH_SPACE) || is_period
                    || (s_tdata == CH_LF) || (s_tdata == CH_NUL);
    assign is_digit  = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
    assign room      = (cnt_reg < CNT_W'(MAX_LEXEME));

    // stored bytes, masked to the current length
    always_comb begin
        lex_text = '0;
        for (int i = 0; i < MAX_LEXEME; i++) begin
            if (cnt_reg > CNT_W'(i)) begin
                lex_text[8*i +: 8] = buf_reg[i];
            end
        end
    end

    always_comb begin
        kw_hit = 1'b0;
        for (int k = 0; k < KW_NUM; k++) begin
            if (KW_LEN[k] == cnt_reg && KW_TEXT[k] == lex_text) begin
                kw_hit = 1'b1;
            end
        end
        kw_hit = kw_hit && !ovf_reg;
    end

    always_comb begin
        if (kw_hit) begin
            tok_class = CLS_KEYWORD;
        end else if (dig_reg) begin
            tok_class = CLS_INTEGER;
        end else if (buf_reg[0] == CH_PLUS || buf_reg[0] == CH_MINUS
                  || buf_reg[0] == CH_STAR || buf_reg[0] == CH_SLASH) begin
            tok_class = CLS_OPERATOR;
        end else begin
            tok_class = CLS_IDENT;
        end
    end

    // lexeme state
    always_comb begin
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        dig_next = dig_reg;
        if (take) begin
            if (is_delim) begin
                cnt_next = '0;
                ovf_next = 1'b0;
                dig_next = 1'b1;
            end else begin
                if (room) begin
                    cnt_next = cnt_reg + 1'b1;
                end else begin
                    ovf_next = 1'b1;
                end
                if (!is_digit) begin
                    dig_next = 1'b0;
                end
            end
        end
    end

    // result register and queued separator
    always_comb begin
        res_valid_next = res_valid_reg;
        sep_pend_next  = sep_pend_reg;
        res_class_next = res_class_reg;
        res_len_next   = res_len_reg;
        res_text_next  = res_text_reg;
        res_trunc_next = res_trunc_reg;
        res_last_next  = res_last_reg;
        if (res_valid_reg && m_tready) begin
            res_valid_next = 1'b0;
        end
        if (sep_pend_reg && m_tready) begin
            res_valid_next = 1'b1;
            sep_pend_next  = 1'b0;
            res_class_next = CLS_SEPARATOR;
            res_len_next   = '0;
            res_text_next  = '0;
            res_trunc_next = 1'b0;
            res_last_next  = 1'b1;
        end
        if (take && is_delim) begin
            if (cnt_reg != '0) begin
                res_valid_next = 1'b1;
                sep_pend_next  = is_period;
                res_class_next = tok_class;
                res_len_next   = cnt_reg;
                res_text_next  = lex_text;
                res_trunc_next = ovf_reg;
                res_last_next  = !is_period;
            end else if (is_period) begin
                res_valid_next = 1'b1;
                res_class_next = CLS_SEPARATOR;
                res_len_next   = '0;
                res_text_next  = '0;
                res_trunc_next = 1'b0;
                res_last_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            dig_reg       <= 1'b1;
            res_valid_reg <= 1'b0;
            sep_pend_reg  <= 1'b0;
        end else begin
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            dig_reg       <= dig_next;
            res_valid_reg <= res_valid_next;
            sep_pend_reg  <= sep_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_class_reg <= res_class_next;
        res_len_reg   <= res_len_next;
        res_text_reg  <= res_text_next;
        res_trunc_reg <= res_trunc_next;
        res_last_reg  <= res_last_next;
        if (take && !is_delim && room) begin
            buf_reg[cnt_reg[IDX_W-1:0]] <= s_tdata;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {3'b000, res_trunc_reg, res_text_reg, res_len_reg};
    assign m_tuser  = res_class_reg;
    assign m_tlast  = res_last_reg;

endmodule
